// File: sv/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// sbsh_pkg
// shared types, constants and tables of the sha-256 byte stream hasher
// ----------------------------------------------------------------------------
package sbsh_pkg;

    localparam int BUF_DEPTH  = 16;
    localparam int HASH_DEPTH = 8;
    localparam int WORD_W     = 32;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_WORD,
        ST_PAD_ZERO,
        ST_PREP,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // what follows the hash update of a block
    typedef enum logic [1:0] {
        FIN_DATA,
        FIN_PAD1,
        FIN_LAST
    } fin_kind_t;

    // controls from the sequencer to the compression datapath
    typedef struct packed {
        logic       load_w;
        logic       load_v;
        logic       round;
        logic       rotate;
        logic [5:0] round_idx;
    } ctl_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

endpackage

// File: sv/sbsh_ram.sv
// ----------------------------------------------------------------------------
// sbsh_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sbsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/sbsh_compress.sv
// ----------------------------------------------------------------------------
// sbsh_compress
// sha-256 round datapath: working variables and rolling message schedule
// ----------------------------------------------------------------------------
module sbsh_compress (
    input  logic          aclk,
    input  sbsh_pkg::ctl_t ctl,
    input  logic [31:0]   buf_rdata,
    input  logic [31:0]   hash_rdata,
    output logic [31:0]   v0
);

    logic [31:0] v_reg   [8];
    logic [31:0] win_reg [16];

    logic [31:0] s0, s1, bs0, bs1, ch, maj, t1, t2, w_new;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    // schedule: window holds w[t] .. w[t+15], w[t] sits at slot 0
    always_comb begin
        s0    = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        s1    = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        w_new = win_reg[0] + s0 + win_reg[9] + s1;
    end

    // round function
    always_comb begin
        bs1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        bs0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + bs1 + ch + sbsh_pkg::round_k(ctl.round_idx) + win_reg[0];
        t2  = bs0 + maj;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_w || ctl.round) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= ctl.load_w ? buf_rdata : w_new;
        end
        if (ctl.load_v) begin
            for (int i = 1; i < 8; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
            v_reg[0] <= hash_rdata;
        end else if (ctl.round) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end else if (ctl.rotate) begin
            for (int i = 0; i < 7; i++) begin
                v_reg[i] <= v_reg[i+1];
            end
            v_reg[7] <= v_reg[0];
        end
    end

    assign v0 = v_reg[0];

endmodule

// File: sv/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// sha-256 of a byte stream, digest given out as eight 32-bit words
// ----------------------------------------------------------------------------
// The block takes a message one byte per input item and hashes it with
// standard SHA-256. Bytes are packed big-endian into a 16-word block ram;
// a plain byte item is taken while the block is idle. The 64th byte of a
// block starts a compression: the block loads the schedule window and
// working variables from the block ram and the hash ram, runs the 64 rounds,
// one round per cycle, and adds the result back into the hash ram, taking no
// item meanwhile. An item with last set pads the block (the 0x80 word, then
// zero or length words in the remaining slots), runs one compression, or two
// when 56 or more bytes sit in the partial block, and then reads out the
// digest one word at a time, word 0 first, final_word marking word 7. The
// next message may start while the last digest word still waits on the
// result port. An item with neither a byte nor last has no effect. The hash
// ram starts from the initial hash values through per-entry valid flags,
// which the end of every digest clears.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    // byte items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data,
    input  logic        s_data_present,
    input  logic        s_last,
    // digest words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_final_word
);

    sbsh_pkg::state_t    state_reg, state_next;
    sbsh_pkg::fin_kind_t fin_kind_reg, fin_kind_next;

    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] count_reg, count_next;
    logic [31:0] word_reg, word_next;
    logic        last_pend_reg, last_pend_next;
    logic        len_en_reg, len_en_next;
    logic [7:0]  hv_valid_reg, hv_valid_next;

    logic        m_valid_reg;
    logic [31:0] m_word_reg;
    logic [2:0]  m_index_reg;
    logic        m_final_reg;
    logic        m_load;

    // ram ports
    logic        buf_we;
    logic [3:0]  buf_waddr, buf_raddr;
    logic [31:0] buf_wdata, buf_rdata;
    logic        hash_we;
    logic [2:0]  hash_waddr, hash_raddr;
    logic [31:0] hash_wdata, hash_ram_rdata, hash_rd;
    logic        hv_fresh_reg;
    logic [31:0] iv_reg;

    sbsh_pkg::ctl_t ctl;
    logic [31:0] v0;

    logic        accept;
    logic        block_full;
    logic        emit_go;
    logic [1:0]  lane;
    logic [31:0] byte_word, pad_word;
    logic [31:0] len_hi, len_lo;

    assign accept     = s_valid && s_ready;
    assign lane       = count_reg[1:0];
    // this byte closes a 64-byte block
    assign block_full = s_data_present && (count_reg[5:0] == 6'd63);
    assign emit_go    = !m_valid_reg || m_ready;
    // message length in bits, modulo 2^64
    assign len_hi     = count_reg[60:29];
    assign len_lo     = {count_reg[28:0], 3'b000};

    // byte packing, the first byte of a word clears it
    assign byte_word = ((lane == 2'd0) ? 32'h0 : word_reg)
                     | ({24'h0, s_data} << {~lane, 3'b000});
    assign pad_word  = ((lane == 2'd0) ? 32'h0 : word_reg)
                     | (32'h0000_0080 << {~lane, 3'b000});

    // entries never written since the last digest read as the initial value
    assign hash_rd = hv_fresh_reg ? iv_reg : hash_ram_rdata;

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sbsh_pkg::ST_IDLE: begin
                if (accept) begin
                    if (block_full) begin
                        state_next = sbsh_pkg::ST_PREP;
                    end else if (s_last) begin
                        state_next = sbsh_pkg::ST_PAD_WORD;
                    end
                end
            end
            sbsh_pkg::ST_PAD_WORD: begin
                state_next = sbsh_pkg::ST_PAD_ZERO;
            end
            sbsh_pkg::ST_PAD_ZERO: begin
                if (cnt_reg[4]) begin
                    state_next = sbsh_pkg::ST_PREP;
                end
            end
            sbsh_pkg::ST_PREP: begin
                if (cnt_reg == 6'd16) begin
                    state_next = sbsh_pkg::ST_ROUND;
                end
            end
            sbsh_pkg::ST_ROUND: begin
                if (cnt_reg == 6'd63) begin
                    state_next = sbsh_pkg::ST_FINAL;
                end
            end
            sbsh_pkg::ST_FINAL: begin
                if (cnt_reg == 6'd8) begin
                    case (fin_kind_reg)
                        sbsh_pkg::FIN_DATA: begin
                            state_next = last_pend_reg ? sbsh_pkg::ST_PAD_WORD
                                                       : sbsh_pkg::ST_IDLE;
                        end
                        sbsh_pkg::FIN_PAD1: state_next = sbsh_pkg::ST_PAD_ZERO;
                        sbsh_pkg::FIN_LAST: state_next = sbsh_pkg::ST_EMIT_RD;
                        default:            state_next = sbsh_pkg::ST_IDLE;
                    endcase
                end
            end
            sbsh_pkg::ST_EMIT_RD: begin
                if (emit_go) begin
                    state_next = sbsh_pkg::ST_EMIT_LD;
                end
            end
            sbsh_pkg::ST_EMIT_LD: begin
                state_next = (cnt_reg == 6'd7) ? sbsh_pkg::ST_IDLE : sbsh_pkg::ST_EMIT_RD;
            end
            default: state_next = sbsh_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // outputs and datapath controls
    // ------------------------------------------------------------------------
    always_comb begin
        s_ready        = 1'b0;
        buf_we         = 1'b0;
        buf_waddr      = count_reg[5:2];
        buf_wdata      = byte_word;
        buf_raddr      = cnt_reg[3:0];
        hash_we        = 1'b0;
        hash_waddr     = cnt_reg[2:0] - 3'd1;
        hash_wdata     = hash_rd + v0;
        hash_raddr     = cnt_reg[2:0];
        ctl            = '0;
        ctl.round_idx  = cnt_reg;
        m_load         = 1'b0;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        word_next      = word_reg;
        fin_kind_next  = fin_kind_reg;
        last_pend_next = last_pend_reg;
        len_en_next    = len_en_reg;
        hv_valid_next  = hv_valid_reg;

        case (state_reg)
            sbsh_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cnt_next = 6'd0;
                if (accept && s_data_present) begin
                    buf_we     = (lane == 2'd3);
                    word_next  = byte_word;
                    count_next = count_reg + 64'd1;
                end
                if (accept && block_full) begin
                    fin_kind_next  = sbsh_pkg::FIN_DATA;
                    last_pend_next = s_last;
                end
            end
            sbsh_pkg::ST_PAD_WORD: begin
                // 0x80 after the last byte, then zero or length words
                buf_we      = 1'b1;
                buf_wdata   = pad_word;
                cnt_next    = {2'b00, count_reg[5:2]} + 6'd1;
                len_en_next = (count_reg[5:3] != 3'd7);
            end
            sbsh_pkg::ST_PAD_ZERO: begin
                if (cnt_reg[4]) begin
                    cnt_next      = 6'd0;
                    fin_kind_next = len_en_reg ? sbsh_pkg::FIN_LAST : sbsh_pkg::FIN_PAD1;
                end else begin
                    buf_we    = 1'b1;
                    buf_waddr = cnt_reg[3:0];
                    if (len_en_reg && (cnt_reg[3:0] == 4'd14)) begin
                        buf_wdata = len_hi;
                    end else if (len_en_reg && (cnt_reg[3:0] == 4'd15)) begin
                        buf_wdata = len_lo;
                    end else begin
                        buf_wdata = 32'h0;
                    end
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            sbsh_pkg::ST_PREP: begin
                // window from the block ram, working variables h7 first
                hash_raddr = ~cnt_reg[2:0];
                ctl.load_w = (cnt_reg != 6'd0);
                ctl.load_v = (cnt_reg != 6'd0) && (cnt_reg <= 6'd8);
                cnt_next   = (cnt_reg == 6'd16) ? 6'd0 : cnt_reg + 6'd1;
            end
            sbsh_pkg::ST_ROUND: begin
                ctl.round = 1'b1;
                cnt_next  = cnt_reg + 6'd1;
            end
            sbsh_pkg::ST_FINAL: begin
                // read h[i], then write h[i] + v[i] while v rotates past slot 0
                if (cnt_reg != 6'd0) begin
                    hash_we    = 1'b1;
                    ctl.rotate = 1'b1;
                    hv_valid_next[hash_waddr] = 1'b1;
                end
                cnt_next = (cnt_reg == 6'd8) ? 6'd0 : cnt_reg + 6'd1;
                if ((cnt_reg == 6'd8) && (fin_kind_reg == sbsh_pkg::FIN_PAD1)) begin
                    len_en_next = 1'b1;
                end
            end
            sbsh_pkg::ST_EMIT_RD: begin
                // waits here until the output register is free next cycle
            end
            sbsh_pkg::ST_EMIT_LD: begin
                m_load = 1'b1;
                if (cnt_reg == 6'd7) begin
                    cnt_next      = 6'd0;
                    count_next    = 64'd0;
                    hv_valid_next = 8'h00;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sbsh_pkg::ST_IDLE;
            fin_kind_reg  <= sbsh_pkg::FIN_DATA;
            cnt_reg       <= 6'd0;
            count_reg     <= 64'd0;
            last_pend_reg <= 1'b0;
            len_en_reg    <= 1'b0;
            hv_valid_reg  <= 8'h00;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fin_kind_reg  <= fin_kind_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            last_pend_reg <= last_pend_next;
            len_en_reg    <= len_en_next;
            hv_valid_reg  <= hv_valid_next;
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        word_reg     <= word_next;
        hv_fresh_reg <= !hv_valid_reg[hash_raddr];
        iv_reg       <= sbsh_pkg::init_h(hash_raddr);
        if (m_load) begin
            m_word_reg  <= hash_rd;
            m_index_reg <= cnt_reg[2:0];
            m_final_reg <= (cnt_reg == 6'd7);
        end
    end

    // ------------------------------------------------------------------------
    // memories and round datapath
    // ------------------------------------------------------------------------
    sbsh_ram #(
        .WIDTH (sbsh_pkg::WORD_W),
        .DEPTH (sbsh_pkg::BUF_DEPTH)
    ) u_block_ram (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    sbsh_ram #(
        .WIDTH (sbsh_pkg::WORD_W),
        .DEPTH (sbsh_pkg::HASH_DEPTH)
    ) u_hash_ram (
        .aclk  (aclk),
        .we    (hash_we),
        .waddr (hash_waddr),
        .wdata (hash_wdata),
        .raddr (hash_raddr),
        .rdata (hash_ram_rdata)
    );

    sbsh_compress u_compress (
        .aclk       (aclk),
        .ctl        (ctl),
        .buf_rdata  (buf_rdata),
        .hash_rdata (hash_rd),
        .v0         (v0)
    );

    assign m_valid       = m_valid_reg;
    assign m_digest_word = m_word_reg;
    assign m_word_index  = m_index_reg;
    assign m_final_word  = m_final_reg;

endmodule
